// ===== hdl/csqf_pkg.sv =====
// ----------------------------------------------------------------------------
// csqf_pkg
// Shared types, constants and helpers for the size-query filter
// ----------------------------------------------------------------------------
package csqf_pkg;

  localparam int REPLY_DEPTH = 32;
  localparam int ADDR_W      = $clog2(REPLY_DEPTH);
  localparam int LEN_W       = $clog2(REPLY_DEPTH + 1);

  localparam int CFG_IDX_W   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 8'd1;

  localparam logic [15:0] ROWS_RESET = 16'd24;
  localparam logic [15:0] COLS_RESET = 16'd80;

  localparam logic [7:0] BYTE_INTRO = 8'h9b;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_Q     = 8'h71;
  localparam logic [7:0] BYTE_R     = 8'h72;
  localparam logic [7:0] BYTE_ONE   = 8'h31;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;

  // reciprocal of ten for 16-bit dividends
  localparam logic [32:0] RECIP_TEN = 33'd52429;
  localparam int          RECIP_SH  = 19;

  localparam logic [1:0] ROUTE_CLIENT = 2'd0;
  localparam logic [1:0] ROUTE_REPLY  = 2'd1;
  localparam logic [1:0] ROUTE_EMPTY  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] MS_NONE  = 2'd0;
  localparam logic [1:0] MS_INTRO = 2'd1;
  localparam logic [1:0] MS_SPACE = 2'd2;

  localparam logic [2:0] HEAD_LAST = 3'd4;

  typedef enum logic [1:0] {
    PUT_HEAD,
    PUT_DIGIT,
    PUT_SEMI,
    PUT_TAIL
  } put_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_EMIT,
    ST_HEAD,
    ST_DIV_ROWS,
    ST_POP_ROWS,
    ST_SEMI,
    ST_DIV_COLS,
    ST_POP_COLS,
    ST_SPACE,
    ST_R
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     rd_capture;
    logic     out_load;
    logic     put;
    put_sel_e put_sel;
    logic     tail_r;
    logic     head_inc;
    logic     conv_load;
    logic     conv_cols;
    logic     div_step;
  } cmd_t;

  typedef struct packed {
    logic acc_op;
    logic acc_build;
    logic acc_none;
    logic rd_avail;
    logic head_last;
    logic quot_zero;
    logic dig_one;
    logic pend_last;
  } status_t;

  function automatic logic [7:0] head_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = BYTE_INTRO;
      3'd1:    b = BYTE_ONE;
      3'd2:    b = BYTE_SEMI;
      3'd3:    b = BYTE_ONE;
      3'd4:    b = BYTE_SEMI;
      default: b = BYTE_SEMI;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/csqf_datapath.sv =====
// ----------------------------------------------------------------------------
// csqf_datapath
// Matcher, size registers, reply memory, decimal converter and output register
// ----------------------------------------------------------------------------
module csqf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_operation_i,
  input  logic [7:0]                     in_data_i,
  input  logic                           cfg_we_i,
  input  logic [csqf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  csqf_pkg::cmd_t                 cmd_i,
  output csqf_pkg::status_t              status_o,
  output logic [1:0]                     out_route_o,
  output logic [7:0]                     out_byte_out_o,
  output logic                           out_last_o
);

  logic [15:0] rows_q, cols_q;
  logic [1:0]  ms_q, ms_d;
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pend_n_q, pend_n_d;
  logic [1:0]  route_q;
  logic        build_d;
  logic        size_ok;

  logic [7:0]                 mem [csqf_pkg::REPLY_DEPTH];
  logic [7:0]                 rdata_q;
  logic [csqf_pkg::LEN_W-1:0] len_q, pos_q, pos_nx;
  logic [2:0]                 hd_cnt_q;

  logic [15:0] conv_q;
  logic [32:0] prod;
  logic [15:0] quot, quot10;
  logic [3:0]  rem;
  logic [3:0]  dig_q [5];
  logic [2:0]  ndig_q;
  logic [7:0]  put_byte;

  assign size_ok = (rows_q != 16'd0) && (cols_q != 16'd0);

  // match step for a written byte
  always_comb begin
    ms_d      = csqf_pkg::MS_NONE;
    pend_d[0] = in_data_i;
    pend_d[1] = in_data_i;
    pend_d[2] = in_data_i;
    pend_n_d  = 2'd0;
    build_d   = 1'b0;
    case (ms_q)
      csqf_pkg::MS_INTRO: begin
        pend_d[0] = csqf_pkg::BYTE_INTRO;
        if (in_data_i == csqf_pkg::BYTE_SPACE) begin
          ms_d = csqf_pkg::MS_SPACE;
        end else if (in_data_i == csqf_pkg::BYTE_INTRO) begin
          ms_d     = csqf_pkg::MS_INTRO;
          pend_n_d = 2'd1;
        end else begin
          pend_n_d = 2'd2;
        end
      end
      csqf_pkg::MS_SPACE: begin
        pend_d[0] = csqf_pkg::BYTE_INTRO;
        pend_d[1] = csqf_pkg::BYTE_SPACE;
        if (in_data_i == csqf_pkg::BYTE_Q) begin
          build_d = size_ok;
        end else if (in_data_i == csqf_pkg::BYTE_INTRO) begin
          ms_d     = csqf_pkg::MS_INTRO;
          pend_n_d = 2'd2;
        end else begin
          pend_n_d = 2'd3;
        end
      end
      default: begin
        if (in_data_i == csqf_pkg::BYTE_INTRO) begin
          ms_d = csqf_pkg::MS_INTRO;
        end else begin
          pend_n_d = 2'd1;
        end
      end
    endcase
  end

  // divide by ten through the reciprocal
  assign prod   = 33'(conv_q) * csqf_pkg::RECIP_TEN;
  assign quot   = 16'(prod[32:csqf_pkg::RECIP_SH]);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = 4'(conv_q - quot10);

  always_comb begin
    case (cmd_i.put_sel)
      csqf_pkg::PUT_HEAD:  put_byte = csqf_pkg::head_byte(hd_cnt_q);
      csqf_pkg::PUT_DIGIT: put_byte = csqf_pkg::BYTE_ZERO + {4'd0, dig_q[0]};
      csqf_pkg::PUT_SEMI:  put_byte = csqf_pkg::BYTE_SEMI;
      csqf_pkg::PUT_TAIL:  put_byte = cmd_i.tail_r ? csqf_pkg::BYTE_R : csqf_pkg::BYTE_SPACE;
      default:             put_byte = csqf_pkg::BYTE_SEMI;
    endcase
  end

  assign pos_nx = pos_q + csqf_pkg::LEN_W'(1);

  assign status_o.acc_op    = in_operation_i;
  assign status_o.acc_build = build_d;
  assign status_o.acc_none  = (pend_n_d == 2'd0);
  assign status_o.rd_avail  = (pos_q < len_q);
  assign status_o.head_last = (hd_cnt_q == csqf_pkg::HEAD_LAST);
  assign status_o.quot_zero = (quot == 16'd0);
  assign status_o.dig_one   = (ndig_q == 3'd1);
  assign status_o.pend_last = (pend_n_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= csqf_pkg::ROWS_RESET;
      cols_q   <= csqf_pkg::COLS_RESET;
      ms_q     <= csqf_pkg::MS_NONE;
      pend_n_q <= 2'd0;
      len_q    <= '0;
      pos_q    <= '0;
      hd_cnt_q <= 3'd0;
      ndig_q   <= 3'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == csqf_pkg::REG_ROWS) begin
        rows_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == csqf_pkg::REG_COLS) begin
        cols_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (in_operation_i == csqf_pkg::OP_READ) begin
          pend_n_q <= 2'd1;
        end else begin
          ms_q     <= ms_d;
          pend_n_q <= pend_n_d;
          if (build_d) begin
            len_q    <= '0;
            pos_q    <= '0;
            hd_cnt_q <= 3'd0;
          end
        end
      end
      if (cmd_i.rd_capture) begin
        if (pos_nx >= len_q) begin
          len_q <= '0;
          pos_q <= '0;
        end else begin
          pos_q <= pos_nx;
        end
      end
      if (cmd_i.out_load) begin
        pend_n_q <= pend_n_q - 2'd1;
      end
      if (cmd_i.put && len_q < csqf_pkg::LEN_W'(csqf_pkg::REPLY_DEPTH)) begin
        len_q <= len_q + csqf_pkg::LEN_W'(1);
      end
      if (cmd_i.head_inc) begin
        hd_cnt_q <= hd_cnt_q + 3'd1;
      end
      if (cmd_i.conv_load) begin
        ndig_q <= 3'd0;
      end else if (cmd_i.div_step) begin
        ndig_q <= ndig_q + 3'd1;
      end else if (cmd_i.put && cmd_i.put_sel == csqf_pkg::PUT_DIGIT) begin
        ndig_q <= ndig_q - 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_operation_i == csqf_pkg::OP_READ) begin
        route_q   <= csqf_pkg::ROUTE_EMPTY;
        pend_q[0] <= 8'd0;
      end else begin
        route_q <= csqf_pkg::ROUTE_CLIENT;
        pend_q  <= pend_d;
      end
    end
    if (cmd_i.rd_capture) begin
      route_q   <= csqf_pkg::ROUTE_REPLY;
      pend_q[0] <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_route_o    <= route_q;
      out_byte_out_o <= pend_q[0];
      out_last_o     <= (pend_n_q == 2'd1);
      pend_q[0]      <= pend_q[1];
      pend_q[1]      <= pend_q[2];
    end
    if (cmd_i.conv_load) begin
      conv_q <= cmd_i.conv_cols ? cols_q : rows_q;
    end else if (cmd_i.div_step) begin
      conv_q <= quot;
    end
    // digit stack: least significant in first, most significant out first
    if (cmd_i.div_step) begin
      dig_q[0] <= rem;
      for (int i = 1; i < 5; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end else if (cmd_i.put && cmd_i.put_sel == csqf_pkg::PUT_DIGIT) begin
      for (int i = 0; i < 4; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
  end

  // reply memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.put && len_q < csqf_pkg::LEN_W'(csqf_pkg::REPLY_DEPTH)) begin
      mem[len_q[csqf_pkg::ADDR_W-1:0]] <= put_byte;
    end
    rdata_q <= mem[pos_q[csqf_pkg::ADDR_W-1:0]];
  end

endmodule

// ===== hdl/csqf_ctrl.sv =====
// ----------------------------------------------------------------------------
// csqf_ctrl
// Sequencer for item acceptance, result beats and reply building
// ----------------------------------------------------------------------------
module csqf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  csqf_pkg::status_t status_i,
  output csqf_pkg::cmd_t    cmd_o
);

  csqf_pkg::state_e state_q, state_d;
  logic             out_free;

  assign in_ready_o = (state_q == csqf_pkg::ST_IDLE);
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      csqf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.acc_op == csqf_pkg::OP_READ) begin
            state_d = status_i.rd_avail ? csqf_pkg::ST_RD : csqf_pkg::ST_EMIT;
          end else if (status_i.acc_build) begin
            state_d = csqf_pkg::ST_HEAD;
          end else if (!status_i.acc_none) begin
            state_d = csqf_pkg::ST_EMIT;
          end
        end
      end
      csqf_pkg::ST_RD: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = csqf_pkg::ST_EMIT;
      end
      csqf_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.pend_last) begin
            state_d = csqf_pkg::ST_IDLE;
          end
        end
      end
      csqf_pkg::ST_HEAD: begin
        cmd_o.put      = 1'b1;
        cmd_o.put_sel  = csqf_pkg::PUT_HEAD;
        cmd_o.head_inc = 1'b1;
        if (status_i.head_last) begin
          cmd_o.conv_load = 1'b1;
          state_d         = csqf_pkg::ST_DIV_ROWS;
        end
      end
      csqf_pkg::ST_DIV_ROWS: begin
        cmd_o.div_step = 1'b1;
        if (status_i.quot_zero) begin
          state_d = csqf_pkg::ST_POP_ROWS;
        end
      end
      csqf_pkg::ST_POP_ROWS: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = csqf_pkg::PUT_DIGIT;
        if (status_i.dig_one) begin
          state_d = csqf_pkg::ST_SEMI;
        end
      end
      csqf_pkg::ST_SEMI: begin
        cmd_o.put       = 1'b1;
        cmd_o.put_sel   = csqf_pkg::PUT_SEMI;
        cmd_o.conv_load = 1'b1;
        cmd_o.conv_cols = 1'b1;
        state_d         = csqf_pkg::ST_DIV_COLS;
      end
      csqf_pkg::ST_DIV_COLS: begin
        cmd_o.div_step = 1'b1;
        if (status_i.quot_zero) begin
          state_d = csqf_pkg::ST_POP_COLS;
        end
      end
      csqf_pkg::ST_POP_COLS: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = csqf_pkg::PUT_DIGIT;
        if (status_i.dig_one) begin
          state_d = csqf_pkg::ST_SPACE;
        end
      end
      csqf_pkg::ST_SPACE: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = csqf_pkg::PUT_TAIL;
        state_d       = csqf_pkg::ST_R;
      end
      csqf_pkg::ST_R: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_sel = csqf_pkg::PUT_TAIL;
        cmd_o.tail_r  = 1'b1;
        state_d       = csqf_pkg::ST_IDLE;
      end
      default: begin
        state_d = csqf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csqf_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/csi_size_query_filter.sv =====
// ----------------------------------------------------------------------------
// csi_size_query_filter
// Swallows the terminal size query in a shell byte stream and serves the reply
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       sink       in_valid_i/in_ready_o, in_operation_i, in_data_i
// out      source     out_valid_o/out_ready_i, out_route_o, out_byte_out_o,
//                     out_last_o
// cfg      sink       cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// one item at a time: a written byte is accepted and then hands out its result
// beats (up to three); a reply read first passes the registered read port, a
// read of the empty buffer goes straight to its beat. after the query byte is
// taken the reply is built: head bytes, rows digits, semicolon, cols digits,
// space and r. a stalled result beat holds the next one back, but
// the output register lets a new item be taken while the last beat waits.
// reset: no prefix held, reply empty, rows 24, cols 80, no memory clearing.
module csi_size_query_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_operation_i,
  input  logic [7:0]                     in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     out_route_o,
  output logic [7:0]                     out_byte_out_o,
  output logic                           out_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [csqf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  csqf_pkg::cmd_t    cmd;
  csqf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  csqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csqf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_operation_i (in_operation_i),
    .in_data_i      (in_data_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_route_o    (out_route_o),
    .out_byte_out_o (out_byte_out_o),
    .out_last_o     (out_last_o)
  );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives shell bytes and reply reads into csi_size_query_filter and checks
// every result beat against a scoreboard that tracks the query matcher and the
// reply buffer, across several terminal sizes written between phases
// ----------------------------------------------------------------------------
module testbench;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 7;
  localparam int PHASE_ITEMS  = 30;

  // index that decodes to no register
  localparam logic [csqf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hff;

  typedef struct packed {
    logic [1:0] route;
    logic [7:0] data;
    logic       last;
  } beat_t;

  class reply_scoreboard;
    logic [15:0] rows;
    logic [15:0] cols;
    logic [1:0]  held;
    logic [7:0]  reply_mem [csqf_pkg::REPLY_DEPTH];
    int unsigned reply_len;
    int unsigned reply_pos;
    beat_t       expected_beats [$];
    int unsigned errors;
    int unsigned beats_checked;

    function new();
      rows          = csqf_pkg::ROWS_RESET;
      cols          = csqf_pkg::COLS_RESET;
      held          = csqf_pkg::MS_NONE;
      reply_len     = 0;
      reply_pos     = 0;
      errors        = 0;
      beats_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void set_reg(logic [csqf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == csqf_pkg::REG_ROWS) begin
        rows = value;
      end else if (idx == csqf_pkg::REG_COLS) begin
        cols = value;
      end
    endfunction

    function void push_beat(logic [1:0] route, logic [7:0] data);
      beat_t b;
      b.route = route;
      b.data  = data;
      b.last  = 1'b0;
      expected_beats.push_back(b);
    endfunction

    function void put_reply(logic [7:0] b);
      if (reply_len < csqf_pkg::REPLY_DEPTH) begin
        reply_mem[reply_len] = b;
        reply_len++;
      end
    endfunction

    function void put_number(int unsigned v);
      logic [7:0]  digits [5];
      int unsigned k;
      k = 0;
      do begin
        digits[k] = csqf_pkg::BYTE_ZERO + 8'(v % 10);
        v = v / 10;
        k++;
      end while (v > 0 && k < 5);
      while (k > 0) begin
        k--;
        put_reply(digits[k]);
      end
    endfunction

    // a zero size swallows the query but keeps the old reply
    function void build_reply();
      if (rows == 16'd0 || cols == 16'd0) return;
      reply_len = 0;
      reply_pos = 0;
      put_reply(csqf_pkg::BYTE_INTRO);
      put_reply(csqf_pkg::BYTE_ONE);
      put_reply(csqf_pkg::BYTE_SEMI);
      put_reply(csqf_pkg::BYTE_ONE);
      put_reply(csqf_pkg::BYTE_SEMI);
      put_number(rows);
      put_reply(csqf_pkg::BYTE_SEMI);
      put_number(cols);
      put_reply(csqf_pkg::BYTE_SPACE);
      put_reply(csqf_pkg::BYTE_R);
    endfunction

    function void note_item(logic op, logic [7:0] data);
      int unsigned n0;
      n0 = expected_beats.size();
      if (op == csqf_pkg::OP_READ) begin
        if (reply_pos < reply_len) begin
          push_beat(csqf_pkg::ROUTE_REPLY, reply_mem[reply_pos]);
          reply_pos++;
          if (reply_pos >= reply_len) begin
            reply_len = 0;
            reply_pos = 0;
          end
        end else begin
          push_beat(csqf_pkg::ROUTE_EMPTY, 8'h00);
        end
      end else begin
        case (held)
          csqf_pkg::MS_INTRO: begin
            if (data == csqf_pkg::BYTE_SPACE) begin
              held = csqf_pkg::MS_SPACE;
            end else begin
              push_beat(csqf_pkg::ROUTE_CLIENT, csqf_pkg::BYTE_INTRO);
              if (data != csqf_pkg::BYTE_INTRO) begin
                held = csqf_pkg::MS_NONE;
                push_beat(csqf_pkg::ROUTE_CLIENT, data);
              end
            end
          end
          csqf_pkg::MS_SPACE: begin
            if (data == csqf_pkg::BYTE_Q) begin
              build_reply();
              held = csqf_pkg::MS_NONE;
            end else begin
              push_beat(csqf_pkg::ROUTE_CLIENT, csqf_pkg::BYTE_INTRO);
              push_beat(csqf_pkg::ROUTE_CLIENT, csqf_pkg::BYTE_SPACE);
              if (data == csqf_pkg::BYTE_INTRO) begin
                held = csqf_pkg::MS_INTRO;
              end else begin
                held = csqf_pkg::MS_NONE;
                push_beat(csqf_pkg::ROUTE_CLIENT, data);
              end
            end
          end
          default: begin
            if (data == csqf_pkg::BYTE_INTRO) begin
              held = csqf_pkg::MS_INTRO;
            end else begin
              held = csqf_pkg::MS_NONE;
              push_beat(csqf_pkg::ROUTE_CLIENT, data);
            end
          end
        endcase
      end
      if (expected_beats.size() > n0) begin
        expected_beats[expected_beats.size() - 1].last = 1'b1;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(logic [1:0] route, logic [7:0] data, logic last);
      beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none,", $time,
                 " got route %0d byte %02h last %0b", route, data, last);
      end else begin
        want = expected_beats.pop_front();
        compare_field("route", want.route, route);
        compare_field("byte", want.data, data);
        compare_field("last", want.last, last);
      end
    endfunction
  endclass

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_ready_o;
  logic                           in_operation_i = csqf_pkg::OP_WRITE;
  logic [7:0]                     in_data_i      = 8'h00;
  logic                           out_valid_o;
  logic                           out_ready_i    = 1'b0;
  logic [1:0]                     out_route_o;
  logic [7:0]                     out_byte_out_o;
  logic                           out_last_o;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [csqf_pkg::CFG_IDX_W-1:0] cfg_index_i    = csqf_pkg::REG_ROWS;
  logic [15:0]                    cfg_data_i     = 16'h0000;

  reply_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int unsigned     stall_cycles = 0;
  int unsigned     items_taken = 0;
  int unsigned     writes_taken = 0;

  csi_size_query_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_operation_i (in_operation_i),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_route_o    (out_route_o),
    .out_byte_out_o (out_byte_out_o),
    .out_last_o     (out_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // result beats are checked before a new item is noted on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_beat(out_route_o, out_byte_out_o, out_last_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_item(in_operation_i, in_data_i);
        items_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_reg(cfg_index_i, cfg_data_i);
        writes_taken++;
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)
          || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb: no beat moved for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(logic op, logic [7:0] data);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    in_operation_i <= op;
    in_data_i      <= data;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // a swallowed query leaves no beat behind, so allow for the reply build
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [csqf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_mix(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned reads;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // full query, sometimes with a read between its bytes, then drain
        send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
        if ($urandom_range(4) == 0) begin
          send_item(csqf_pkg::OP_READ, 8'($urandom_range(255)));
          sent++;
        end
        send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
        send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_Q);
        sent += 3;
        reads = $urandom_range(20, 1);
        repeat (reads) send_item(csqf_pkg::OP_READ, 8'($urandom_range(255)));
        sent += reads;
      end else if (pick < 55) begin
        send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
        sent++;
        if ($urandom_range(1) == 1) begin
          send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
          sent++;
        end
        case ($urandom_range(3))
          0:       b = csqf_pkg::BYTE_INTRO;
          1:       b = csqf_pkg::BYTE_SPACE;
          2:       b = csqf_pkg::BYTE_Q;
          default: b = 8'($urandom_range(255));
        endcase
        send_item(csqf_pkg::OP_WRITE, b);
        sent++;
      end else if (pick < 80) begin
        send_item(csqf_pkg::OP_WRITE, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_item(csqf_pkg::OP_READ, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain bytes and a read of the empty buffer, reset size in force
    send_item(csqf_pkg::OP_WRITE, 8'h41);
    send_item(csqf_pkg::OP_WRITE, 8'h00);
    send_item(csqf_pkg::OP_WRITE, 8'hff);
    send_item(csqf_pkg::OP_READ, 8'hff);
    // repeated intro, then a prefix broken after the space
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
    send_item(csqf_pkg::OP_WRITE, 8'h78);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, 8'h7a);
    // intro breaks a held prefix and starts a new one that completes
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_Q);
    repeat (3) send_item(csqf_pkg::OP_READ, 8'h00);
    // a new query part way through a reply starts it afresh
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_Q);
    send_item(csqf_pkg::OP_READ, 8'h5a);
    // zero rows: query swallowed, old reply carries on
    settle();
    write_reg(csqf_pkg::REG_ROWS, 16'h0000);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_INTRO);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_SPACE);
    send_item(csqf_pkg::OP_WRITE, csqf_pkg::BYTE_Q);
    repeat (2) send_item(csqf_pkg::OP_READ, 8'ha5);

    settle();
    write_reg(csqf_pkg::REG_ROWS, 16'hffff);
    write_reg(csqf_pkg::REG_COLS, 16'hffff);
    write_reg(REG_UNUSED, 16'h0001);
    run_mix(PHASE_ITEMS);

    settle();
    no_idle = 1'b1;
    write_reg(csqf_pkg::REG_ROWS, 16'd1);
    write_reg(csqf_pkg::REG_COLS, 16'd1);
    run_mix(PHASE_ITEMS);

    settle();
    no_idle = 1'b0;
    write_reg(csqf_pkg::REG_ROWS, 16'($urandom_range(65535, 1)));
    write_reg(csqf_pkg::REG_COLS, 16'($urandom_range(65535, 1)));
    run_mix(PHASE_ITEMS);

    settle();
    write_reg(csqf_pkg::REG_ROWS, 16'($urandom_range(9, 1)));
    write_reg(csqf_pkg::REG_COLS, 16'($urandom_range(9999, 10)));
    run_mix(PHASE_ITEMS);

    settle();
    $display("tb: %0d items and %0d register writes taken, %0d result beats checked",
             items_taken, writes_taken, sb.beats_checked);
    $display("tb: sizes covered: reset, zero rows, 65535x65535, 1x1 and two random pairs");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d beats still expected", sb.errors, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== csi_size_query_filter.f =====
hdl/csqf_pkg.sv
hdl/csqf_datapath.sv
hdl/csqf_ctrl.sv
hdl/csi_size_query_filter.sv
bench/testbench.sv
